[rtl/ibp_pkg.sv]
// ibp_pkg: shared constants, controller state codes and the command/status
// bundles for the indirect block path block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibp_pkg;

  // block map geometry
  localparam int unsigned DIRECT_COUNT    = 12;
  localparam int unsigned INDIRECT_LEVELS = 3;
  localparam int unsigned MAX_PAIRS       = 4;

  // field widths
  localparam int unsigned BN_W    = 48;
  localparam int unsigned SLOT_W  = 14;
  localparam int unsigned LCNT_W  = 3;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned E_W     = 6;  // holds up to INDIRECT_LEVELS * SHIFT_MAX + SHIFT_MAX
  localparam int unsigned LVL_W   = 2;  // holds 0 .. INDIRECT_LEVELS
  localparam int unsigned PAIR_W  = 2;  // index into the pair registers

  // pointer shift register limits
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd8;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd14;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;

  // controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_FIND = 6'b000100,
    ST_INIT = 6'b001000,
    ST_WALK = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic find_step;
    logic init;
    logic walk_step;
  } ibp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic direct;     // magnitude below the direct count
    logic found;      // remainder fits the current level
    logic last_find;  // no deeper level left to try
    logic walk_stop;  // this walk step is the final one
  } ibp_status_t;

endpackage

`default_nettype wire

[rtl/ibp_ctrl.sv]
// ibp_ctrl: sequencing state machine for the indirect block path.
// Depends on ibp_pkg for state codes and the command/status bundles.
`timescale 1ns / 1ps
`default_nettype none

module ibp_ctrl
  import ibp_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  input  ibp_status_t status_i,
  output logic        busy,
  output logic        valid_o,
  output ibp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = status_i.direct ? ST_DONE : ST_FIND;
      end
      ST_FIND: begin
        cmd_o.find_step = 1'b1;
        if (status_i.found) begin
          state_d = ST_INIT;
        end else if (status_i.last_find) begin
          state_d = ST_DONE;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_stop) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);

endmodule

`default_nettype wire

[rtl/ibp_datapath.sv]
// ibp_datapath: shift register, level search and path walk registers.
// Depends on ibp_pkg; driven by commands from ibp_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ibp_datapath
  import ibp_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire        [SHIFT_W-1:0] cfg_wdata_i,
  input  wire signed [BN_W-1:0]   logical_block_i,
  input  ibp_cmd_t                cmd_i,
  output ibp_status_t             status_o,
  output logic                    status_bit_o,
  output logic       [LCNT_W-1:0] level_count_o,
  output logic signed [BN_W-1:0]  meta_block_0_o,
  output logic       [SLOT_W-1:0] slot_0_o,
  output logic signed [BN_W-1:0]  meta_block_1_o,
  output logic       [SLOT_W-1:0] slot_1_o,
  output logic signed [BN_W-1:0]  meta_block_2_o,
  output logic       [SLOT_W-1:0] slot_2_o,
  output logic signed [BN_W-1:0]  meta_block_3_o,
  output logic       [SLOT_W-1:0] slot_3_o
);

  logic [SHIFT_W-1:0] shift_q;

  logic signed [BN_W:0]   realbn_q;
  logic [BN_W-1:0]        mag_q;
  logic [BN_W-1:0]        rem_q, rem_d;
  logic [BN_W-1:0]        acc_q, acc_d;
  logic [E_W-1:0]         e_q, e_d;
  logic [LVL_W-1:0]       i_q, i_d;
  logic signed [BN_W:0]   metalbn_q, metalbn_d;
  logic                   too_big_q, too_big_d;
  logic [LCNT_W-1:0]      levels_q, levels_d;
  logic signed [BN_W:0]   meta_q [MAX_PAIRS];
  logic [SLOT_W-1:0]      slot_q [MAX_PAIRS];

  // pointer shift register, saturates into its legal range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < SHIFT_MIN) begin
        shift_q <= SHIFT_MIN;
      end else if (cfg_wdata_i > SHIFT_MAX) begin
        shift_q <= SHIFT_MAX;
      end else begin
        shift_q <= cfg_wdata_i;
      end
    end
  end

  // sign fold of the incoming block number
  logic [BN_W-1:0] mag_in;
  assign mag_in = logical_block_i[BN_W-1] ? (BN_W'(0) - logical_block_i) : logical_block_i;

  // level search: q = 1 << (e + shift)
  logic [E_W-1:0]  find_sh;
  logic [BN_W-1:0] q_val;
  assign find_sh = e_q + E_W'(shift_q);
  assign q_val   = BN_W'(1) << find_sh;

  // first pair: -(acc + lvl) computed as ~(acc + lvl - 1)
  logic [LVL_W-1:0]     lvl;
  logic signed [LVL_W:0] lvl_m1;
  logic signed [BN_W:0] init_sum;
  assign lvl      = LVL_W'(INDIRECT_LEVELS) - i_q;
  assign lvl_m1   = $signed({1'b0, lvl}) - 3'sd1;
  assign init_sum = $signed({1'b0, acc_q}) + (BN_W+1)'(lvl_m1);

  // walk step: slot offset and the part of rem that it covers
  logic [BN_W-1:0]   nmask;
  logic [BN_W-1:0]   off_field;
  logic [SLOT_W-1:0] off;
  logic              meta_hit;
  assign nmask     = (BN_W'(1) << shift_q) - BN_W'(1);
  assign off       = SLOT_W'(rem_q >> e_q) & SLOT_W'(nmask);
  assign off_field = rem_q & (nmask << e_q);
  assign meta_hit  = (metalbn_q == realbn_q);

  // status toward the controller
  assign status_o.direct    = (mag_q < BN_W'(DIRECT_COUNT));
  assign status_o.found     = ((rem_q >> find_sh) == '0);
  assign status_o.last_find = (i_q == LVL_W'(1));
  assign status_o.walk_stop = meta_hit || (i_q == LVL_W'(INDIRECT_LEVELS));

  // control-side next values
  always_comb begin
    rem_d     = rem_q;
    acc_d     = acc_q;
    e_d       = e_q;
    i_d       = i_q;
    metalbn_d = metalbn_q;
    too_big_d = too_big_q;
    levels_d  = levels_q;
    if (cmd_i.load) begin
      acc_d     = BN_W'(DIRECT_COUNT);
      e_d       = '0;
      i_d       = LVL_W'(INDIRECT_LEVELS);
      too_big_d = 1'b0;
      levels_d  = '0;
    end
    if (cmd_i.prep) begin
      rem_d = mag_q - BN_W'(DIRECT_COUNT);
    end
    if (cmd_i.find_step && !status_o.found) begin
      if (status_o.last_find) begin
        too_big_d = 1'b1;
      end else begin
        e_d   = find_sh;
        rem_d = rem_q - q_val;
        acc_d = acc_q + q_val;
        i_d   = i_q - LVL_W'(1);
      end
    end
    if (cmd_i.init) begin
      metalbn_d = ~init_sum;
      levels_d  = LCNT_W'(1);
    end
    if (cmd_i.walk_step && !meta_hit) begin
      levels_d  = levels_q + LCNT_W'(1);
      metalbn_d = metalbn_q + (BN_W+1)'(1) - $signed({1'b0, off_field});
      e_d       = (e_q >= E_W'(shift_q)) ? (e_q - E_W'(shift_q)) : '0;
      i_d       = i_q + LVL_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      too_big_q <= 1'b0;
      levels_q  <= '0;
      i_q       <= '0;
      e_q       <= '0;
    end else begin
      too_big_q <= too_big_d;
      levels_q  <= levels_d;
      i_q       <= i_d;
      e_q       <= e_d;
    end
  end

  // working payload registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    acc_q     <= acc_d;
    metalbn_q <= metalbn_d;
    if (cmd_i.load) begin
      realbn_q <= {logical_block_i[BN_W-1], logical_block_i};
      mag_q    <= mag_in;
    end
  end

  // path pair registers, cleared per item so unused pairs read zero
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < MAX_PAIRS; k++) begin
        meta_q[k] <= '0;
        slot_q[k] <= '0;
      end
    end else if (cmd_i.init) begin
      meta_q[0] <= ~init_sum;
      slot_q[0] <= SLOT_W'(lvl);
    end else if (cmd_i.walk_step && !meta_hit && (levels_q < LCNT_W'(MAX_PAIRS))) begin
      meta_q[levels_q[PAIR_W-1:0]] <= metalbn_q;
      slot_q[levels_q[PAIR_W-1:0]] <= off;
    end
  end

  assign status_bit_o   = too_big_q;
  assign level_count_o  = levels_q;
  assign meta_block_0_o = meta_q[0][BN_W-1:0];
  assign slot_0_o       = slot_q[0];
  assign meta_block_1_o = meta_q[1][BN_W-1:0];
  assign slot_1_o       = slot_q[1];
  assign meta_block_2_o = meta_q[2][BN_W-1:0];
  assign slot_2_o       = slot_q[2];
  assign meta_block_3_o = meta_q[3][BN_W-1:0];
  assign slot_3_o       = slot_q[3];

endmodule

`default_nettype wire

[rtl/indirect_block_path.sv]
// indirect_block_path: top level joining ibp_ctrl and ibp_datapath.
// Depends on ibp_pkg, ibp_ctrl and ibp_datapath.
//
//   channel   direction  handshake            payload
//   request   in         start & !busy        logical_block_i
//   result    out        valid_o (one cycle)  status_o, level_count_o, meta/slot pairs
//   config    in         cfg_we_i             cfg_wdata_i (pointer shift)
//
// an item runs these steps after the accepting edge: a prepare step, a search
// step per indirect level tried (1 to 3), a first-pair step, walk steps no more
// than search steps and fewer when the walk reaches the named metadata block,
// a result step; direct items and items too big for the last level skip to the result
// busy is high from the accepting edge until the result cycle has ended
// reset clears the controller and loads the pointer shift with 8; no receiver stall
`timescale 1ns / 1ps
`default_nettype none

module indirect_block_path
  import ibp_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  output logic                     busy,
  input  wire signed [BN_W-1:0]    logical_block_i,
  input  wire                      cfg_we_i,
  input  wire        [SHIFT_W-1:0] cfg_wdata_i,
  output logic                     valid_o,
  output logic                     status_o,
  output logic       [LCNT_W-1:0]  level_count_o,
  output logic signed [BN_W-1:0]   meta_block_0_o,
  output logic       [SLOT_W-1:0]  slot_0_o,
  output logic signed [BN_W-1:0]   meta_block_1_o,
  output logic       [SLOT_W-1:0]  slot_1_o,
  output logic signed [BN_W-1:0]   meta_block_2_o,
  output logic       [SLOT_W-1:0]  slot_2_o,
  output logic signed [BN_W-1:0]   meta_block_3_o,
  output logic       [SLOT_W-1:0]  slot_3_o
);

  ibp_cmd_t    cmd;
  ibp_status_t dp_status;

  // sequencing
  ibp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (dp_status),
    .busy     (busy),
    .valid_o  (valid_o),
    .cmd_o    (cmd)
  );

  // arithmetic and result registers
  ibp_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .logical_block_i (logical_block_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .status_bit_o    (status_o),
    .level_count_o   (level_count_o),
    .meta_block_0_o  (meta_block_0_o),
    .slot_0_o        (slot_0_o),
    .meta_block_1_o  (meta_block_1_o),
    .slot_1_o        (slot_1_o),
    .meta_block_2_o  (meta_block_2_o),
    .slot_2_o        (slot_2_o),
    .meta_block_3_o  (meta_block_3_o),
    .slot_3_o        (slot_3_o)
  );

endmodule

`default_nettype wire
